/* rtl/core/rhc_pkg.sv */
// Shared types, constants and the divider step for the RGB to HSV/HSL converter.
// No dependencies; every other file of the block but rhc_if imports this package.
package rhc_pkg;

    localparam int DEF_HUE_SECTOR_STEPS = 4096;
    localparam int DIV_STEPS = 16;              // quotient bits, one per cell
    localparam int DSR_W     = 8;               // divisor width
    localparam int DVD_W     = DIV_STEPS + DSR_W;

    // color_model register codes
    localparam logic MODE_HSV = 1'b0;
    localparam logic MODE_HSL = 1'b1;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // one restoring-division lane
    typedef struct packed {
        logic [DSR_W-1:0]     rem;
        logic [DIV_STEPS-1:0] dvd_lo;
        logic [DIV_STEPS-1:0] quo;
        logic [DSR_W-1:0]     dsr;
    } t_lane;

    // per-pixel side info carried alongside the division
    typedef struct packed {
        logic    hue_zero;
        t_sector sector;
        logic    diff_neg;
        logic    sat_zero;
        logic [8:0] level;
    } t_side;

    typedef struct packed {
        t_side side;
        t_lane hue;
        t_lane sat;
    } t_pipe;

    function automatic t_lane div_step(t_lane l);
        logic [DSR_W:0] part;
        t_lane          o;
        o        = l;
        part     = {l.rem, l.dvd_lo[DIV_STEPS-1]};
        o.dvd_lo = {l.dvd_lo[DIV_STEPS-2:0], 1'b0};
        if (part >= {1'b0, l.dsr}) begin
            o.rem = DSR_W'(part - {1'b0, l.dsr});
            o.quo = {l.quo[DIV_STEPS-2:0], 1'b1};
        end else begin
            o.rem = part[DSR_W-1:0];
            o.quo = {l.quo[DIV_STEPS-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

/* rtl/core/rhc_if.sv */
// Channel interfaces of the converter: pixel in, result out, mode write.
// No dependencies.
interface rhc_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
    modport source(output valid, output blue_in, output green_in, output red_in, input ready);
    modport sink(input valid, input blue_in, input green_in, input red_in, output ready);
endinterface

interface rhc_res_if;
    logic        valid;
    logic        ready;
    logic [14:0] hue_out;
    logic [15:0] saturation_out;
    logic [8:0]  level_out;
    modport source(output valid, output hue_out, output saturation_out, output level_out,
                   input ready);
    modport sink(input valid, input hue_out, input saturation_out, input level_out,
                 output ready);
endinterface

interface rhc_cfg_if;
    logic valid;
    logic ready;
    logic color_model;
    modport source(output valid, output color_model, input ready);
    modport sink(input valid, input color_model, output ready);
endinterface

/* rtl/core/rhc_front.sv */
// Front stage: max/min, hue sector, dividends and divisors, registered.
// Depends on rhc_pkg.
module rhc_front
    import rhc_pkg::*;
#(
    parameter int HUE_SECTOR_STEPS = DEF_HUE_SECTOR_STEPS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_color_model,
    input  logic       i_up_valid,
    output logic       o_up_ready,
    input  logic [7:0] i_blue,
    input  logic [7:0] i_green,
    input  logic [7:0] i_red,
    output logic       o_dn_valid,
    input  logic       i_dn_ready,
    output t_pipe      o_dn_data
);

    localparam int SW = $clog2(HUE_SECTOR_STEPS + 1);
    localparam logic [SW-1:0] STEPS = SW'(HUE_SECTOR_STEPS);

    logic       r_valid;
    t_pipe      r_data;
    t_pipe      n_data;
    logic [7:0] mx, mn, delta, abs_diff, den, alt;
    logic [8:0] sum;
    logic [DVD_W-1:0] hue_dvd, sat_dvd;
    logic signed [8:0] diff;

    assign o_up_ready = !r_valid || i_dn_ready;
    assign o_dn_valid = r_valid;
    assign o_dn_data  = r_data;

    always_comb begin
        mx = i_blue;
        mn = i_blue;
        if (i_green > mx) mx = i_green;
        if (i_red > mx)   mx = i_red;
        if (i_green < mn) mn = i_green;
        if (i_red < mn)   mn = i_red;
        delta = mx - mn;
        sum   = {1'b0, mx} + {1'b0, mn};
        alt   = 8'(9'd510 - sum);
        n_data = '0;
        if (mx == i_blue) begin
            n_data.side.sector = SEC_BLUE;
            diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end else if (mx == i_green) begin
            n_data.side.sector = SEC_GREEN;
            diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n_data.side.sector = SEC_RED;
            diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end
        abs_diff = diff[8] ? 8'(-diff) : diff[7:0];
        // HSL divisor: min(sum, 510 - sum), never above 255
        if (i_color_model == MODE_HSL) begin
            den = (sum < 9'd255) ? sum[7:0] : alt;
            n_data.side.level = sum;
        end else begin
            den = mx;
            n_data.side.level = {1'b0, mx};
        end
        hue_dvd = DVD_W'(STEPS) * DVD_W'(abs_diff);
        sat_dvd = {delta, 16'h0000} - DVD_W'(delta);   // 65535 * delta
        n_data.side.hue_zero = (delta == 8'd0);
        n_data.side.diff_neg = diff[8];
        n_data.side.sat_zero = (den == 8'd0);
        n_data.hue.rem    = hue_dvd[DVD_W-1:DIV_STEPS];
        n_data.hue.dvd_lo = hue_dvd[DIV_STEPS-1:0];
        n_data.hue.dsr    = delta;
        n_data.sat.rem    = sat_dvd[DVD_W-1:DIV_STEPS];
        n_data.sat.dvd_lo = sat_dvd[DIV_STEPS-1:0];
        n_data.sat.dsr    = den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_up_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_up_valid && o_up_ready) begin
            r_data <= n_data;
        end
    end

endmodule

/* rtl/core/rhc_div_cell.sv */
// One divider cell: a restoring step on the hue and saturation lanes, registered.
// Depends on rhc_pkg (t_pipe, div_step).
module rhc_div_cell
    import rhc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_up_valid,
    output logic  o_up_ready,
    input  t_pipe i_up_data,
    output logic  o_dn_valid,
    input  logic  i_dn_ready,
    output t_pipe o_dn_data
);

    logic  r_valid;
    t_pipe r_data;
    t_pipe n_data;

    assign o_up_ready = !r_valid || i_dn_ready;
    assign o_dn_valid = r_valid;
    assign o_dn_data  = r_data;

    always_comb begin
        n_data     = i_up_data;
        n_data.hue = div_step(i_up_data.hue);
        n_data.sat = div_step(i_up_data.sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_up_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_up_valid && o_up_ready) begin
            r_data <= n_data;
        end
    end

endmodule

/* rtl/core/rhc_back.sv */
// Back stage: rounding, hue assembly and wrap, saturation clamp; output register.
// Depends on rhc_pkg.
module rhc_back
    import rhc_pkg::*;
#(
    parameter int HUE_SECTOR_STEPS = DEF_HUE_SECTOR_STEPS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_up_valid,
    output logic        o_up_ready,
    input  t_pipe       i_up_data,
    output logic        o_dn_valid,
    input  logic        i_dn_ready,
    output logic [14:0] o_hue,
    output logic [15:0] o_sat,
    output logic [8:0]  o_level
);

    localparam int HW = $clog2(6 * HUE_SECTOR_STEPS + 1);
    localparam logic [HW-1:0] TURN  = HW'(6 * HUE_SECTOR_STEPS);
    localparam logic [HW-1:0] OFF_G = HW'(2 * HUE_SECTOR_STEPS);
    localparam logic [HW-1:0] OFF_B = HW'(4 * HUE_SECTOR_STEPS);

    logic          r_valid;
    logic [HW-1:0] r_hue;
    logic [15:0]   r_sat;
    logic [8:0]    r_level;
    logic [HW-1:0] n_hue, q_up, q_dn, off, hue_raw;
    logic [15:0]   n_sat;
    logic [16:0]   sat_q;
    logic [DSR_W:0] hue_rem2, sat_rem2;
    logic          up_h, dn_h, up_s;

    assign o_up_ready = !r_valid || i_dn_ready;
    assign o_dn_valid = r_valid;
    assign o_hue      = 15'(r_hue);
    assign o_sat      = r_sat;
    assign o_level    = r_level;

    always_comb begin
        hue_rem2 = {i_up_data.hue.rem, 1'b0};
        sat_rem2 = {i_up_data.sat.rem, 1'b0};
        up_h = hue_rem2 >= {1'b0, i_up_data.hue.dsr};   // half rounds up
        dn_h = hue_rem2 >  {1'b0, i_up_data.hue.dsr};   // half rounds down
        up_s = sat_rem2 >= {1'b0, i_up_data.sat.dsr};
        q_up = HW'(i_up_data.hue.quo) + HW'(up_h);
        q_dn = HW'(i_up_data.hue.quo) + HW'(dn_h);
        case (i_up_data.side.sector)
            SEC_BLUE:  off = OFF_B;
            SEC_GREEN: off = OFF_G;
            default:   off = '0;
        endcase
        if (i_up_data.side.sector == SEC_RED) begin
            // negative hue wraps by one turn; a fraction that rounds to zero stays zero
            if (i_up_data.side.diff_neg && (q_up != '0)) hue_raw = TURN - q_up;
            else if (i_up_data.side.diff_neg)            hue_raw = '0;
            else                                         hue_raw = q_up;
        end else begin
            hue_raw = i_up_data.side.diff_neg ? (off - q_dn) : (off + q_up);
        end
        if (i_up_data.side.hue_zero) n_hue = '0;
        else if (hue_raw > TURN)     n_hue = TURN;
        else                         n_hue = hue_raw;
        sat_q = 17'(i_up_data.sat.quo) + 17'(up_s);
        if (i_up_data.side.sat_zero)  n_sat = '0;
        else if (sat_q > 17'd65535)   n_sat = 16'hFFFF;
        else                          n_sat = sat_q[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_valid <= i_up_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_up_valid && o_up_ready) begin
            r_hue   <= n_hue;
            r_sat   <= n_sat;
            r_level <= i_up_data.side.level;
        end
    end

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_hue <= TURN))
        else $error("hue beyond full turn");

    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_up_valid && o_up_ready && i_up_data.side.hue_zero) |=>
            (r_valid && (r_hue == '0) && (r_sat == '0)))
        else $error("grey pixel with nonzero hue or saturation");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_valid)
        else $error("result valid right after reset");

endmodule

/* rtl/core/rgb_to_hsv_hsl_converter.sv */
// Top level of the RGB to HSV/HSL converter: front stage, divider cell chain, back stage.
// Depends on rhc_pkg, rhc_if, rhc_front, rhc_div_cell, rhc_back.
//
//  channel  | dir | modport | payload
//  ---------+-----+---------+-----------------------------------------------
//  i_pix    | in  | sink    | blue_in[7:0], green_in[7:0], red_in[7:0]
//  o_res    | out | source  | hue_out[14:0], saturation_out[15:0], level_out[8:0]
//  i_cfg    | in  | sink    | color_model (0 = HSV, 1 = HSL), always ready
//
// Throughput one pixel per clock while the result side keeps up; a pixel
// passes through 18 registered stages to result valid: one front stage, 16
// divider cells (one quotient bit each), one output stage. The 16-bit
// saturation quotient sets the length of the chain.
// Reset is synchronous, active low; it empties the chain and selects HSV.
// Each stage holds while its successor is full and stalled, so bubbles squeeze
// out and input is taken as long as any stage downstream can move.
module rgb_to_hsv_hsl_converter
    import rhc_pkg::*;
#(
    parameter int HUE_SECTOR_STEPS = DEF_HUE_SECTOR_STEPS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rhc_pix_if.sink   i_pix,
    rhc_res_if.source o_res,
    rhc_cfg_if.sink   i_cfg
);

    // mode register; to be written only while the pipe is empty, a rule on the user that the block does not enforce
    logic r_color_model;

    // handshake and payload between stages: index 0 is the front stage output,
    // index k+1 the output of divider cell g_cell[k]
    logic  stg_valid [DIV_STEPS+1];
    logic  stg_ready [DIV_STEPS+1];
    t_pipe stg_data  [DIV_STEPS+1];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_model <= 1'b0;
        end else if (i_cfg.valid) begin
            r_color_model <= i_cfg.color_model;
        end
    end

    // max/min, sector select, dividends (steps * |diff|, 65535 * delta)
    rhc_front #(
        .HUE_SECTOR_STEPS(HUE_SECTOR_STEPS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_color_model(r_color_model),
        .i_up_valid   (i_pix.valid),
        .o_up_ready   (i_pix.ready),
        .i_blue       (i_pix.blue_in),
        .i_green      (i_pix.green_in),
        .i_red        (i_pix.red_in),
        .o_dn_valid   (stg_valid[0]),
        .i_dn_ready   (stg_ready[0]),
        .o_dn_data    (stg_data[0])
    );

    // restoring division, MSB first, both quotients side by side
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
        rhc_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_up_valid(stg_valid[k]),
            .o_up_ready(stg_ready[k]),
            .i_up_data (stg_data[k]),
            .o_dn_valid(stg_valid[k+1]),
            .i_dn_ready(stg_ready[k+1]),
            .o_dn_data (stg_data[k+1])
        );
    end

    // rounding, sector offset and wrap, clamp; doubles as the output register
    rhc_back #(
        .HUE_SECTOR_STEPS(HUE_SECTOR_STEPS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_up_valid(stg_valid[DIV_STEPS]),
        .o_up_ready(stg_ready[DIV_STEPS]),
        .i_up_data (stg_data[DIV_STEPS]),
        .o_dn_valid(o_res.valid),
        .i_dn_ready(o_res.ready),
        .o_hue     (o_res.hue_out),
        .o_sat     (o_res.saturation_out),
        .o_level   (o_res.level_out)
    );

endmodule

/* tb/rhc_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the RGB to HSV/HSL converter: watches pixel, result and mode channels.
// Depends on rhc_pkg and the channel interfaces in rhc_if.
module rhc_checker
    import rhc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rhc_pix_if          i_pix,
    rhc_res_if          i_res,
    rhc_cfg_if          i_cfg,
    output int unsigned o_fail_cnt,
    output int unsigned o_pending
);

    typedef struct packed {
        logic [14:0] hue;
        logic [15:0] sat;
        logic [8:0]  level;
    } t_hsx;

    t_hsx exp_hsx_q[$];
    logic color_mode;

    function automatic t_hsx predict_hsx(input logic [7:0] b, input logic [7:0] g,
                                         input logic [7:0] r, input logic hsl);
        int      mx, mn, delta, sum, den, diff, offset, lvl;
        longint  num, mag, q, turn;
        t_sector sec;
        t_hsx    o;
        turn = 6 * DEF_HUE_SECTOR_STEPS;
        mx = int'(b);
        mn = int'(b);
        if (int'(g) > mx) mx = int'(g);
        if (int'(r) > mx) mx = int'(r);
        if (int'(g) < mn) mn = int'(g);
        if (int'(r) < mn) mn = int'(r);
        delta = mx - mn;
        sum   = mx + mn;

        // hue: blue wins ties, then green
        if (delta == 0) begin
            q = 0;
        end else begin
            if (mx == int'(b)) sec = SEC_BLUE;
            else if (mx == int'(g)) sec = SEC_GREEN;
            else sec = SEC_RED;
            case (sec)
                SEC_BLUE: begin
                    offset = 4;
                    diff   = int'(r) - int'(g);
                end
                SEC_GREEN: begin
                    offset = 2;
                    diff   = int'(b) - int'(r);
                end
                default: begin
                    offset = 0;
                    diff   = int'(g) - int'(b);
                end
            endcase
            num = longint'(DEF_HUE_SECTOR_STEPS) * longint'(offset * delta + diff);
            mag = (num < 0) ? -num : num;
            q   = (2 * mag + delta) / (2 * longint'(delta));
            if (num < 0) q = -q;
            if (q < 0) q += turn;
            if (q < 0) q = 0;
            if (q > turn) q = turn;
        end
        o.hue = 15'(q);

        if (hsl == MODE_HSL) begin
            den = (sum < 510 - sum) ? sum : 510 - sum;
            lvl = sum;
        end else begin
            den = mx;
            lvl = mx;
        end
        if (den == 0) begin
            q = 0;
        end else begin
            q = (2 * 65535 * longint'(delta) + den) / (2 * longint'(den));
            if (q > 65535) q = 65535;
        end
        o.sat   = 16'(q);
        o.level = 9'(lvl);
        return o;
    endfunction

    task automatic log_mismatch(input string what, input t_hsx want, input t_hsx got);
        if (o_fail_cnt < 10)
            $display("%t rhc_checker: %s exp hue=%0d sat=%0d lvl=%0d got hue=%0d sat=%0d lvl=%0d",
                     $realtime, what, want.hue, want.sat, want.level,
                     got.hue, got.sat, got.level);
        o_fail_cnt++;
    endtask

    initial o_fail_cnt = 0;

    always @(posedge i_clk) begin : scoreboard
        t_hsx got;
        t_hsx want;
        if (!i_rst_n) begin
            exp_hsx_q.delete();
            color_mode <= MODE_HSV;
            o_pending  <= 0;
        end else begin
            // results first, so a same-edge pixel never pairs with its own transaction
            if (i_res.valid && i_res.ready) begin
                got = '{i_res.hue_out, i_res.saturation_out, i_res.level_out};
                if (exp_hsx_q.size() == 0) begin
                    log_mismatch("unexpected result", '0, got);
                end else begin
                    want = exp_hsx_q.pop_front();
                    if (got.hue !== want.hue || got.sat !== want.sat
                            || got.level !== want.level)
                        log_mismatch("field mismatch", want, got);
                end
            end
            if (i_pix.valid && i_pix.ready)
                exp_hsx_q.push_back(predict_hsx(i_pix.blue_in, i_pix.green_in,
                                                i_pix.red_in, color_mode));
            if (i_cfg.valid && i_cfg.ready)
                color_mode <= i_cfg.color_model;
            o_pending <= exp_hsx_q.size();
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top for rgb_to_hsv_hsl_converter: clock, reset, pixel and mode stimulus,
// result-side stall pattern and the verdict. Depends on rhc_pkg, rhc_if, rhc_checker.
module tb_top
    import rhc_pkg::*;
();

    localparam int   CYCLE_CAP  = 200000;  // generous watchdog limit for a clean run
    localparam int   LONG_HOLD  = 120;     // well past the 18-deep pipeline
    localparam int   TAIL_WAIT  = 40;      // latency plus margin after the last result
    localparam int   PHASE_PIX  = 90;      // five random phases, ~450 pixels

    // corner pixels, packed {blue, green, red}
    localparam logic [23:0] CORNER_PIX [12] = '{
        24'h000000,   // black: zero divisor in both modes
        24'hFFFFFF,   // white: zero HSL divisor, level 510
        24'h808080,   // mid grey, hue 0
        24'h0000FF,   // pure red, full saturation
        24'h00FF00,   // pure green
        24'hFF0000,   // pure blue
        24'hFFFF00,   // blue/green tie on max -> blue sector
        24'h00FFFF,   // green/red tie on max -> green sector
        24'hFF00FF,   // blue/red tie on max -> blue sector
        24'h0100FF,   // red max, blue above green: negative hue wraps by a full turn
        24'h010102,   // tiny delta near black
        24'h007F80    // sum of 128 in HSL, on the sum branch of the divisor
    };

    logic clk = 1'b0;
    logic rst_n;

    rhc_pix_if pix_ch();
    rhc_res_if res_ch();
    rhc_cfg_if cfg_ch();

    int unsigned fail_cnt;
    int unsigned pending;

    int unsigned cycle_cnt  = 0;
    int unsigned stall_cnt  = 0;   // cycles the block refused an offered pixel
    int unsigned n_sent     = 0;
    int unsigned n_writes   = 0;
    bit          hold_req   = 1'b0;

    rgb_to_hsv_hsl_converter dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix_ch.sink),
        .o_res   (res_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    rhc_checker chk (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_pix      (pix_ch),
        .i_res      (res_ch),
        .i_cfg      (cfg_ch),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog plus input backpressure accounting
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (pix_ch.valid && !pix_ch.ready)
            stall_cnt <= stall_cnt + 1;
        if (cycle_cnt == CYCLE_CAP) begin
            $display("tb_top: timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: stall pattern of its own. Each span picks a style:
    // always ready, mostly ready, mostly stalled, or toggling. A hold request
    // from the stimulus side drops ready during a LONG_HOLD wait, so the
    // pipeline fills and pushes back on the pixel input.
    // ------------------------------------------------------------------
    initial begin : result_ready_gen
        int style;
        int span;
        res_ch.ready <= 1'b0;
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(16, 120);
            repeat (span) begin
                @(posedge clk);
                if (hold_req) begin
                    hold_req = 1'b0;
                    res_ch.ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge clk);
                end
                case (style)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: res_ch.ready <= ~res_ch.ready;
                endcase
            end
        end
    end

    // Offer one pixel and hold it until the transaction. Valid is left high;
    // the caller lowers it only when a gap follows.
    task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
        pix_ch.valid    <= 1'b1;
        pix_ch.blue_in  <= b;
        pix_ch.green_in <= g;
        pix_ch.red_in   <= r;
        do @(posedge clk); while (!pix_ch.ready);
        n_sent++;
    endtask

    // Stop offering and wait until every predicted result has come back.
    // The first edge lets the checker count a transaction taken this step.
    task automatic wait_results_drained();
        pix_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Mode writes only happen with the pipeline empty.
    task automatic set_color_model(input logic mode);
        wait_results_drained();
        cfg_ch.valid       <= 1'b1;
        cfg_ch.color_model <= mode;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        n_writes++;
    endtask

    // Random pixel with a bias toward the interesting shapes: greys, ties on
    // the maximum, fully saturated colors and very small deltas.
    task automatic make_pixel(output logic [7:0] b, output logic [7:0] g, output logic [7:0] r);
        logic [7:0] v[3];
        logic [7:0] t;
        int         kind;
        int         rot;
        int         hi;
        int         base;
        kind = $urandom_range(0, 9);
        case (kind)
            4: begin
                v[0] = 8'($urandom_range(0, 255));
                v[1] = v[0];
                v[2] = v[0];
            end
            5: begin
                hi   = $urandom_range(1, 255);
                v[0] = 8'(hi);
                v[1] = 8'(hi);
                v[2] = 8'($urandom_range(0, hi - 1));
            end
            6: begin
                v[0] = 8'hFF;
                v[1] = 8'h00;
                v[2] = 8'($urandom_range(0, 255));
            end
            7: begin
                base = $urandom_range(0, 250);
                v[0] = 8'(base + $urandom_range(0, 5));
                v[1] = 8'(base + $urandom_range(0, 5));
                v[2] = 8'(base + $urandom_range(0, 5));
            end
            default: begin
                v[0] = 8'($urandom_range(0, 255));
                v[1] = 8'($urandom_range(0, 255));
                v[2] = 8'($urandom_range(0, 255));
            end
        endcase
        rot = $urandom_range(0, 2);
        b = v[rot];
        g = v[(rot + 1) % 3];
        r = v[(rot + 2) % 3];
        if ($urandom_range(0, 1) == 1) begin
            t = g;
            g = r;
            r = t;
        end
    endtask

    // Bursts of random length with random gaps; a zero gap keeps valid high
    // across bursts. hold_at / pause_at (< 0 = off) trigger the long result
    // hold and a full drain partway through the stream.
    task automatic pixel_stream(input int n_pix, input int hold_at, input int pause_at);
        logic [7:0] b, g, r;
        int         done;
        int         burst;
        int         gap;
        done = 0;
        while (done < n_pix) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && done < n_pix; k++) begin
                make_pixel(b, g, r);
                send_pixel(b, g, r);
                done++;
                if (done == hold_at)
                    hold_req = 1'b1;
                if (done == pause_at)
                    wait_results_drained();
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0 && done < n_pix) begin
                pix_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic corner_pixels();
        for (int k = 0; k < 12; k++) begin
            send_pixel(CORNER_PIX[k][23:16], CORNER_PIX[k][15:8], CORNER_PIX[k][7:0]);
            if ($urandom_range(0, 2) == 0) begin
                pix_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
        end
    endtask

    initial begin : stimulus
        int n_corner;
        rst_n              <= 1'b0;
        pix_ch.valid       <= 1'b0;
        pix_ch.blue_in     <= 8'h00;
        pix_ch.green_in    <= 8'h00;
        pix_ch.red_in      <= 8'h00;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.color_model <= MODE_HSV;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners in both modes
        set_color_model(MODE_HSV);
        corner_pixels();
        set_color_model(MODE_HSL);
        corner_pixels();
        n_corner = n_sent;

        // random phases, alternating the mode; phases two and four carry the long
        // result hold, phase three a full drain mid-stream
        set_color_model(MODE_HSV);
        pixel_stream(PHASE_PIX, -1, -1);
        set_color_model(MODE_HSL);
        pixel_stream(PHASE_PIX, 20, -1);
        set_color_model(MODE_HSV);
        pixel_stream(PHASE_PIX, -1, 45);
        set_color_model(MODE_HSL);
        pixel_stream(PHASE_PIX, 60, -1);
        set_color_model(MODE_HSV);
        pixel_stream(PHASE_PIX, -1, -1);

        wait_results_drained();
        repeat (TAIL_WAIT) @(posedge clk);

        $display("tb_top: %0d pixels (%0d corner cases), %0d mode writes across HSV and HSL",
                 n_sent, n_corner, n_writes);
        $display("tb_top: input held off on %0d cycles, %0d cycles total, %0d mismatches",
                 stall_cnt, cycle_cnt, fail_cnt);
        if (fail_cnt == 0 && pending == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

/* rgb_to_hsv_hsl_converter.f */
rtl/core/rhc_pkg.sv
rtl/core/rhc_if.sv
rtl/core/rhc_front.sv
rtl/core/rhc_div_cell.sv
rtl/core/rhc_back.sv
rtl/core/rgb_to_hsv_hsl_converter.sv
tb/rhc_checker.sv
tb/tb_top.sv
